@@ rtl/lcg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and font table
// Glyph beat passed from the font lookup to the column serializer, and the
// 38-glyph font (A-Z, 0-9, space, colon) as a lookup function.
// ----------------------------------------------------------------------------
package lcg_pkg;

	localparam int GLYPH_SLOTS = 6;
	localparam int BYTE_W      = 8;
	localparam int NCOLS_W     = 3;
	localparam int COL_IDX_W   = 3;

	localparam logic [7:0] LOWER_FIRST = 8'h61;
	localparam logic [7:0] LOWER_LAST  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef logic [GLYPH_SLOTS-1:0][BYTE_W-1:0] glyph_cols_t;

	typedef struct packed {
		logic                valid;
		logic                hit;
		logic [NCOLS_W-1:0]  ncols;
		glyph_cols_t         cols;
	} glyph_beat_t;

	function automatic glyph_beat_t mk_glyph(
		input logic [NCOLS_W-1:0] n,
		input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
		input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
		glyph_beat_t g;
		g.valid = 1'b1;
		g.hit   = 1'b1;
		g.ncols = n;
		g.cols  = {b5, b4, b3, b2, b1, b0};
		return g;
	endfunction

	// Fold lower case, then look the code up; a miss returns hit low.
	function automatic glyph_beat_t font_lookup(input logic [7:0] code_in);
		logic [7:0]  code;
		glyph_beat_t g;
		code = code_in;
		if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
			code = code - CASE_OFFSET;
		end
		unique case (code)
			8'h41: g = mk_glyph(3'd4, 8'hFE, 8'h11, 8'hFE, 8'h00, 8'h00, 8'h00);
			8'h42: g = mk_glyph(3'd4, 8'hFF, 8'h89, 8'h76, 8'h00, 8'h00, 8'h00);
			8'h43: g = mk_glyph(3'd4, 8'h7E, 8'h81, 8'hC3, 8'h00, 8'h00, 8'h00);
			8'h44: g = mk_glyph(3'd4, 8'hFF, 8'h81, 8'h7E, 8'h00, 8'h00, 8'h00);
			8'h45: g = mk_glyph(3'd4, 8'hFF, 8'h89, 8'h81, 8'h00, 8'h00, 8'h00);
			8'h46: g = mk_glyph(3'd4, 8'hFF, 8'h09, 8'h01, 8'h00, 8'h00, 8'h00);
			8'h47: g = mk_glyph(3'd4, 8'hFE, 8'h81, 8'h72, 8'h00, 8'h00, 8'h00);
			8'h48: g = mk_glyph(3'd4, 8'hFF, 8'h18, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h49: g = mk_glyph(3'd4, 8'h81, 8'hFF, 8'h81, 8'h00, 8'h00, 8'h00);
			8'h4A: g = mk_glyph(3'd4, 8'h41, 8'h81, 8'h7F, 8'h00, 8'h00, 8'h00);
			8'h4B: g = mk_glyph(3'd4, 8'hFF, 8'h18, 8'hE7, 8'h00, 8'h00, 8'h00);
			8'h4C: g = mk_glyph(3'd4, 8'hFF, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00);
			8'h4D: g = mk_glyph(3'd6, 8'hFF, 8'h04, 8'h08, 8'h04, 8'hFF, 8'h00);
			8'h4E: g = mk_glyph(3'd6, 8'hFF, 8'h07, 8'h38, 8'hC0, 8'hFF, 8'h00);
			8'h4F: g = mk_glyph(3'd4, 8'h7E, 8'h81, 8'h7E, 8'h00, 8'h00, 8'h00);
			8'h50: g = mk_glyph(3'd4, 8'hFF, 8'h09, 8'h0F, 8'h00, 8'h00, 8'h00);
			8'h51: g = mk_glyph(3'd5, 8'h7E, 8'hA1, 8'hC1, 8'h7E, 8'h00, 8'h00);
			8'h52: g = mk_glyph(3'd4, 8'hFF, 8'h39, 8'hCF, 8'h00, 8'h00, 8'h00);
			8'h53: g = mk_glyph(3'd4, 8'h86, 8'h89, 8'h71, 8'h00, 8'h00, 8'h00);
			8'h54: g = mk_glyph(3'd4, 8'h01, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00);
			8'h55: g = mk_glyph(3'd4, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h56: g = mk_glyph(3'd4, 8'h7F, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00);
			8'h57: g = mk_glyph(3'd6, 8'hFF, 8'h40, 8'h20, 8'h40, 8'hFF, 8'h00);
			8'h58: g = mk_glyph(3'd6, 8'hC3, 8'h2C, 8'h30, 8'h2C, 8'hC3, 8'h00);
			8'h59: g = mk_glyph(3'd5, 8'h83, 8'h8C, 8'h68, 8'h1F, 8'h00, 8'h00);
			8'h5A: g = mk_glyph(3'd6, 8'hC3, 8'hA1, 8'h91, 8'h8D, 8'hC3, 8'h00);
			8'h30: g = mk_glyph(3'd4, 8'hFF, 8'h81, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h31: g = mk_glyph(3'd4, 8'h82, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00);
			8'h32: g = mk_glyph(3'd4, 8'hF2, 8'h91, 8'hDE, 8'h00, 8'h00, 8'h00);
			8'h33: g = mk_glyph(3'd4, 8'h42, 8'h91, 8'h7E, 8'h00, 8'h00, 8'h00);
			8'h34: g = mk_glyph(3'd4, 8'h1F, 8'h10, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h35: g = mk_glyph(3'd4, 8'hDF, 8'h91, 8'hF1, 8'h00, 8'h00, 8'h00);
			8'h36: g = mk_glyph(3'd4, 8'hFF, 8'h91, 8'hF1, 8'h00, 8'h00, 8'h00);
			8'h37: g = mk_glyph(3'd4, 8'h01, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h38: g = mk_glyph(3'd4, 8'hFF, 8'h91, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h39: g = mk_glyph(3'd4, 8'h9F, 8'h91, 8'hFF, 8'h00, 8'h00, 8'h00);
			8'h20: g = mk_glyph(3'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			8'h3A: g = mk_glyph(3'd3, 8'h00, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00);
			default: begin
				g       = '0;
				g.valid = 1'b1;
			end
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

@@ rtl/lcg_font.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_font: character code to glyph lookup
// Folds case, looks the code up in the font and registers the glyph for
// one cycle toward the serializer.
// ----------------------------------------------------------------------------
module lcg_font (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          char_code,
	output lcg_pkg::glyph_beat_t     glyph
);

	lcg_pkg::glyph_beat_t            look;
	logic                            valid_q;
	logic                            hit_q;
	logic [lcg_pkg::NCOLS_W-1:0]     ncols_q;
	lcg_pkg::glyph_cols_t            cols_q;

	assign look = lcg_pkg::font_lookup(char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hit_q   <= look.hit;
			ncols_q <= look.ncols;
			cols_q  <= look.cols;
		end
	end

	assign glyph = '{valid: valid_q, hit: hit_q, ncols: ncols_q, cols: cols_q};

endmodule
`default_nettype wire

@@ rtl/lcg_serial.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_serial: column byte serializer
// Holds the glyph's column bytes in a byte shift line; shifts the current
// column MSB first into the output register, one bit per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcg_serial #(
	parameter int COLUMN_BITS       = 8,
	parameter int MAX_GLYPH_COLUMNS = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lcg_pkg::glyph_beat_t            glyph,
	output logic                                 active,
	output logic                                 bit_valid,
	input  wire logic                            bit_stall,
	output logic                                 serial_bit,
	output logic                                 latch_after,
	output logic [lcg_pkg::COL_IDX_W-1:0]        column_index,
	output logic                                 last_bit
);

	localparam int CNT_W = (COLUMN_BITS > 1) ? $clog2(COLUMN_BITS) : 1;
	localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(COLUMN_BITS - 1);
	localparam logic [3:0] MAX_COLS = 4'(MAX_GLYPH_COLUMNS);

	lcg_pkg::glyph_cols_t                cols_q;
	logic [COLUMN_BITS-1:0]              shreg_q;
	logic [CNT_W-1:0]                    bitcnt_q;
	logic [lcg_pkg::COL_IDX_W-1:0]       colcnt_q;
	logic [lcg_pkg::COL_IDX_W-1:0]       lastcol_q;
	logic                                active_q;
	logic                                bit_valid_q;
	logic                                serial_bit_q;
	logic                                latch_after_q;
	logic [lcg_pkg::COL_IDX_W-1:0]       column_index_q;
	logic                                last_bit_q;

	logic                                adv;
	logic                                col_end;
	logic                                glyph_end;
	logic [3:0]                          ncols_ext;
	logic [3:0]                          used_cols;
	logic [COLUMN_BITS+7:0]              first_ext;
	logic [COLUMN_BITS+7:0]              next_ext;

	assign adv       = active_q && (!bit_valid_q || !bit_stall);
	assign col_end   = (bitcnt_q == BIT_LAST);
	assign glyph_end = col_end && (colcnt_q == lastcol_q);
	assign ncols_ext = {1'b0, glyph.ncols};
	assign used_cols = (ncols_ext > MAX_COLS) ? MAX_COLS : ncols_ext;
	// Column bytes sit in the low bits; wider columns lead with zeros.
	assign first_ext = {{COLUMN_BITS{1'b0}}, glyph.cols[0]};
	assign next_ext  = {{COLUMN_BITS{1'b0}}, cols_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			bit_valid_q <= 1'b0;
		end else begin
			if (glyph.valid) begin
				active_q <= glyph.hit;
			end else if (adv && glyph_end) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				bit_valid_q <= 1'b1;
			end else if (!bit_stall) begin
				bit_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (glyph.valid) begin
			cols_q    <= glyph.cols;
			shreg_q   <= first_ext[COLUMN_BITS-1:0];
			bitcnt_q  <= '0;
			colcnt_q  <= '0;
			lastcol_q <= lcg_pkg::COL_IDX_W'(used_cols - 4'd1);
		end else if (adv) begin
			if (col_end) begin
				// advance to the next column byte
				cols_q   <= {8'h00, cols_q[lcg_pkg::GLYPH_SLOTS-1:1]};
				shreg_q  <= next_ext[COLUMN_BITS-1:0];
				bitcnt_q <= '0;
				colcnt_q <= colcnt_q + lcg_pkg::COL_IDX_W'(1);
			end else begin
				shreg_q  <= shreg_q << 1;
				bitcnt_q <= bitcnt_q + CNT_W'(1);
			end
		end
		if (adv) begin
			serial_bit_q   <= shreg_q[COLUMN_BITS-1];
			latch_after_q  <= col_end;
			column_index_q <= colcnt_q;
			last_bit_q     <= glyph_end;
		end
	end

	assign active       = active_q;
	assign bit_valid    = bit_valid_q;
	assign serial_bit   = serial_bit_q;
	assign latch_after  = latch_after_q;
	assign column_index = column_index_q;
	assign last_bit     = last_bit_q;

`ifndef SYNTHESIS
	a_last_is_latch: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid_q && last_bit_q |-> latch_after_q)
		else $error("last bit beat without latch mark");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		glyph.valid |-> !active_q)
		else $error("glyph loaded while serializer busy");

	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> bitcnt_q <= BIT_LAST)
		else $error("bit counter out of range");

	a_colcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> colcnt_q <= lastcol_q)
		else $error("column counter past last column");
`endif

endmodule
`default_nettype wire

@@ rtl/led_column_character_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_column_character_generator_unit: font column serializer
// Looks a character up in the LED font and shifts its columns out bit by bit.
//
//   channel | signals                                          | dir
//   char    | char_valid, char_stall, char_code                | in
//   bit     | bit_valid, bit_stall, serial_bit, latch_after,   | out
//           | column_index, last_bit                           |
//
// One character goes through a lookup registered in the font stage, a load
// into the serializer, then one bit per cycle from the column shift register
// unless bit_stall holds it. A code outside the font gives no beats.
// The next character is taken once the last bit enters the output register.
// A bit_stall on a valid bit holds the output register and the shift register.
// Reset clears only the control flags; no clearing pass.
// ----------------------------------------------------------------------------
module led_column_character_generator_unit #(
	parameter int COLUMN_BITS       = 8,
	parameter int MAX_GLYPH_COLUMNS = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [7:0]                    char_code,
	output logic                               bit_valid,
	input  wire logic                          bit_stall,
	output logic                               serial_bit,
	output logic                               latch_after,
	output logic [lcg_pkg::COL_IDX_W-1:0]      column_index,
	output logic                               last_bit
);

	lcg_pkg::glyph_beat_t glyph;
	logic                 active;
	logic                 take;

	assign char_stall = glyph.valid || active;
	assign take       = char_valid && !char_stall;

	lcg_font u_font (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_code),
		.glyph     (glyph)
	);

	lcg_serial #(
		.COLUMN_BITS       (COLUMN_BITS),
		.MAX_GLYPH_COLUMNS (MAX_GLYPH_COLUMNS)
	) u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.glyph        (glyph),
		.active       (active),
		.bit_valid    (bit_valid),
		.bit_stall    (bit_stall),
		.serial_bit   (serial_bit),
		.latch_after  (latch_after),
		.column_index (column_index),
		.last_bit     (last_bit)
	);

endmodule
`default_nettype wire
